// File: rtl/ultrasonic_ranger_with_segment_display_top_defines.svh
// assertion helpers for the checker file
`ifndef ULTRASONIC_RANGER_WITH_SEGMENT_DISPLAY_TOP_DEFINES_SVH
`define ULTRASONIC_RANGER_WITH_SEGMENT_DISPLAY_TOP_DEFINES_SVH

// property that must hold in the same cycle
`define USRNG_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent now, consequent in the next cycle
`define USRNG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/usrng_pkg.sv
package usrng_pkg;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W = 8;
  localparam int OUT_TDATA_W = 32;
  localparam int CRYS_W = 18;
  localparam int DIST_W = 14;
  localparam logic [DIST_W-1:0] DIST_MAX = 14'd9999;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t REG_TRIGGER  = 3'd0;
  localparam cfg_idx_t REG_TIMEOUT  = 3'd1;
  localparam cfg_idx_t REG_NUM      = 3'd2;
  localparam cfg_idx_t REG_DEN      = 3'd3;
  localparam cfg_idx_t REG_DWELL    = 3'd4;
  localparam cfg_idx_t REG_INTERVAL = 3'd5;

  // result word, last field in the lowest bits
  typedef struct packed {
    logic [2:0]        pad;
    logic              no_echo_indicator;
    logic              distance_done;
    logic [DIST_W-1:0] distance;
    logic [7:0]        segments;
    logic [3:0]        digit_enable;
    logic              trigger_out;
  } out_item_t;

  // common-anode codes for 0..9
  function automatic logic [7:0] seg_code(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hc0;
      4'd1: s = 8'hf9;
      4'd2: s = 8'ha4;
      4'd3: s = 8'hb0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hf8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = 8'hff;
    endcase
    return s;
  endfunction

  // active-low select, only the first four positions have a line
  function automatic logic [3:0] digit_en(input logic [2:0] idx);
    logic [3:0] e;
    e = 4'hf;
    if (idx < 3'd4) e[idx[1:0]] = 1'b0;
    return e;
  endfunction

endpackage

// File: rtl/ultrasonic_ranger_with_segment_display_top.sv
// Ultrasonic echo ranger with a multiplexed 4-digit common-anode display. Each request on the
// in_ channel is one timer tick carrying the sampled echo level in in_tdata[0], and each gives
// exactly one result on the out_ channel: trigger drive, digit select, segment code, held
// distance, a done pulse and the no-echo indicator. Only the tick that ends a measurement
// needs the sequencer: on a falling echo the count is scaled by 17/100 with a reciprocal
// multiply, then by the numerator, then divided by the denominator in a restoring divider,
// one quotient bit a cycle; a timeout or a zero denominator only refills the display digits.
// in_tready is low meanwhile. Registers are written through the APB-style port at byte
// address 4*index; only write them while idle.
module ultrasonic_ranger_with_segment_display_top #(
  parameter int COUNT_WIDTH = 16,
  parameter int DIGITS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] echo_level
  input  logic [usrng_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] trigger_out, [4:1] digit_enable, [12:5] segments, [26:13] distance,
  // [27] distance_done, [28] no_echo_indicator
  output logic [usrng_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [usrng_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [usrng_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [usrng_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  import usrng_pkg::*;

  localparam int IDXW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int PW = COUNT_WIDTH + 5 + CRYS_W;
  localparam int STEPW = $clog2(PW);
  localparam int CMPW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int RECW = COUNT_WIDTH + 31;
  localparam logic [27:0] REC_M = 28'd171798692;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [IDXW-1:0] LAST_DIGIT = IDXW'(DIGITS - 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_TRIG  = 2'd1;
  localparam logic [1:0] PH_WAIT  = 2'd2;
  localparam logic [1:0] PH_COUNT = 2'd3;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REC  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_SAT  = 3'd4;
  localparam logic [2:0] S_BCD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // configuration
  logic [9:0]        trig_ticks_r;
  logic [15:0]       timeout_r;
  logic [CRYS_W-1:0] num_r;
  logic [CRYS_W-1:0] den_r;
  logic [15:0]       dwell_r;
  logic [15:0]       interval_r;

  // ranging and display state
  logic [1:0]             phase_r, phase_nxt;
  logic [15:0]            pc_r, pc_nxt;
  logic [COUNT_WIDTH-1:0] echo_cnt_r, echo_cnt_nxt;
  logic [DIST_W-1:0]      held_r;
  logic                   ind_r, ind_nxt;
  logic [IDXW-1:0]        digit_idx_r, digit_idx_nxt;
  logic [15:0]            dwell_cnt_r, dwell_cnt_nxt;
  logic [3:0]             digit_r [DIGITS];

  // sequencer and divider
  logic [2:0]        seq_r;
  logic [PW-1:0]     q_r;
  logic [CRYS_W-1:0] rem_r;
  logic [CRYS_W-1:0] div_r;
  logic [STEPW-1:0]  step_r;
  logic [DIST_W-1:0] bcd_v_r;
  logic [IDXW-1:0]   bcd_pos_r;
  logic [IDXW-1:0]   sel_idx_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic echo, accept, out_free, out_load, trig, done_echo, done_to;
  logic cfg_wr;
  cfg_idx_t cfg_idx;

  logic [CRYS_W:0]   cand;
  logic              qbit;
  logic [RECW-1:0]   rec_prod;
  logic [29:0]       recip_prod;
  logic [DIST_W-1:0] tenth;
  logic [DIST_W-1:0] digit_val;
  logic [PW-1:0]     count17;
  out_item_t         simple_item;

  assign echo = in_tdata[0];
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (seq_r == S_IDLE) && out_free;
  assign accept = in_tvalid && in_tready;
  assign out_load = (accept && !done_echo && !done_to) || (seq_r == S_OUT && out_free);
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_idx = cfg_paddr[4:2];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      REG_TRIGGER:  cfg_prdata = 32'(trig_ticks_r);
      REG_TIMEOUT:  cfg_prdata = 32'(timeout_r);
      REG_NUM:      cfg_prdata = 32'(num_r);
      REG_DEN:      cfg_prdata = 32'(den_r);
      REG_DWELL:    cfg_prdata = 32'(dwell_r);
      REG_INTERVAL: cfg_prdata = 32'(interval_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_ticks_r <= 10'd20;
      timeout_r <= 16'd6400;
      num_r <= 18'd126000;
      den_r <= 18'd120000;
      dwell_r <= 16'd1250;
      interval_r <= 16'd60000;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TRIGGER:  trig_ticks_r <= cfg_pwdata[9:0];
        REG_TIMEOUT:  timeout_r <= cfg_pwdata[15:0];
        REG_NUM:      num_r <= cfg_pwdata[CRYS_W-1:0];
        REG_DEN:      den_r <= cfg_pwdata[CRYS_W-1:0];
        REG_DWELL:    dwell_r <= cfg_pwdata[15:0];
        REG_INTERVAL: interval_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // next ranging state for one tick
  always_comb begin
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [15:0] pc_inc;
    phase_nxt = phase_r;
    pc_nxt = pc_r;
    echo_cnt_nxt = echo_cnt_r;
    ind_nxt = ind_r;
    trig = 1'b0;
    done_echo = 1'b0;
    done_to = 1'b0;
    pc_inc = pc_r + 16'd1;
    cnt_inc = (echo_cnt_r < COUNT_MAX) ? echo_cnt_r + 1'b1 : echo_cnt_r;
    case (phase_r)
      PH_IDLE: begin
        pc_nxt = pc_inc;
        if (pc_inc >= interval_r) begin
          phase_nxt = PH_TRIG;
          pc_nxt = '0;
        end
      end
      PH_TRIG: begin
        trig = 1'b1;
        pc_nxt = pc_inc;
        if (pc_inc >= 16'(trig_ticks_r)) begin
          phase_nxt = PH_WAIT;
          pc_nxt = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          phase_nxt = PH_COUNT;
          echo_cnt_nxt = '0;
        end
      end
      default: begin
        if (!echo) begin
          done_echo = 1'b1;
        end else begin
          echo_cnt_nxt = cnt_inc;
          if (CMPW'(cnt_inc) >= CMPW'(timeout_r) || cnt_inc == COUNT_MAX) begin
            done_to = 1'b1;
            ind_nxt = !ind_r;
          end
        end
        if (done_echo || done_to) begin
          phase_nxt = PH_IDLE;
          pc_nxt = '0;
        end
      end
    endcase
    dwell_cnt_nxt = dwell_cnt_r + 16'd1;
    digit_idx_nxt = digit_idx_r;
    if (dwell_cnt_nxt >= dwell_r) begin
      dwell_cnt_nxt = '0;
      digit_idx_nxt = (digit_idx_r == LAST_DIGIT) ? '0 : digit_idx_r + 1'b1;
    end
  end

  // restoring divide step, divisor at most CRYS_W bits
  assign cand = {rem_r, q_r[PW-1]};
  assign qbit = (cand >= {1'b0, div_r});

  // x / 100 as (x >> 2) / 25 by reciprocal, exact below 2^30
  assign rec_prod = RECW'(q_r[COUNT_WIDTH+4:2]) * RECW'(REC_M);

  // v / 10 by reciprocal, exact below 20480
  assign recip_prod = 30'(bcd_v_r) * 30'd52429;
  assign tenth = DIST_W'(recip_prod[29:19]);
  assign digit_val = bcd_v_r - ((tenth << 3) + (tenth << 1));

  assign count17 = (PW'(echo_cnt_r) << 4) + PW'(echo_cnt_r);

  always_comb begin
    simple_item = '0;
    simple_item.trigger_out = trig;
    simple_item.digit_enable = digit_en(3'(digit_idx_r));
    simple_item.segments = seg_code(digit_r[digit_idx_r]);
    simple_item.distance = held_r;
    simple_item.distance_done = 1'b0;
    simple_item.no_echo_indicator = ind_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      pc_r <= '0;
      echo_cnt_r <= '0;
      held_r <= '0;
      ind_r <= 1'b0;
      digit_idx_r <= '0;
      dwell_cnt_r <= '0;
      seq_r <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIGITS; i++) digit_r[i] <= '0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (seq_r)
        S_IDLE: begin
          if (accept) begin
            phase_r <= phase_nxt;
            pc_r <= pc_nxt;
            echo_cnt_r <= echo_cnt_nxt;
            ind_r <= ind_nxt;
            digit_idx_r <= digit_idx_nxt;
            dwell_cnt_r <= dwell_cnt_nxt;
            sel_idx_r <= digit_idx_r;
            bcd_pos_r <= LAST_DIGIT;
            if (done_echo && den_r != '0) begin
              q_r <= count17;
              seq_r <= S_REC;
            end else if (done_echo || done_to) begin
              held_r <= done_to ? '0 : DIST_MAX;
              bcd_v_r <= done_to ? '0 : DIST_MAX;
              seq_r <= S_BCD;
            end else begin
              out_data_r <= simple_item;
            end
          end
        end
        S_REC: begin
          q_r <= PW'(rec_prod[RECW-1:32]);
          seq_r <= S_MUL;
        end
        S_DIV2: begin
          rem_r <= qbit ? CRYS_W'(cand - {1'b0, div_r}) : cand[CRYS_W-1:0];
          q_r <= {q_r[PW-2:0], qbit};
          step_r <= step_r + 1'b1;
          if (step_r == STEPW'(PW - 1)) seq_r <= S_SAT;
        end
        S_MUL: begin
          // first quotient fits COUNT_WIDTH+5 bits
          q_r <= PW'(q_r[COUNT_WIDTH+4:0] * num_r);
          rem_r <= '0;
          div_r <= den_r;
          step_r <= '0;
          seq_r <= S_DIV2;
        end
        S_SAT: begin
          held_r <= (q_r > PW'(DIST_MAX)) ? DIST_MAX : q_r[DIST_W-1:0];
          bcd_v_r <= (q_r > PW'(DIST_MAX)) ? DIST_MAX : q_r[DIST_W-1:0];
          seq_r <= S_BCD;
        end
        S_BCD: begin
          digit_r[bcd_pos_r] <= digit_val[3:0];
          bcd_v_r <= tenth;
          bcd_pos_r <= bcd_pos_r - 1'b1;
          if (bcd_pos_r == '0) seq_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r <= '{pad: '0,
                            no_echo_indicator: ind_r,
                            distance_done: 1'b1,
                            distance: held_r,
                            segments: seg_code(digit_r[sel_idx_r]),
                            digit_enable: digit_en(3'(sel_idx_r)),
                            trigger_out: 1'b0};
            seq_r <= S_IDLE;
          end
        end
        default: seq_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/usrng_checker.sv
`include "ultrasonic_ranger_with_segment_display_top_defines.svh"

module usrng_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [usrng_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import usrng_pkg::*;

  out_item_t item;
  assign item = out_item_t'(out_tdata);

  `USRNG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `USRNG_ASSERT_NOW(a_dist_range, !out_tvalid || item.distance <= DIST_MAX, "distance above 9999")
  `USRNG_ASSERT_NOW(a_one_digit, !out_tvalid || $countones(~item.digit_enable) <= 1, "more than one digit enabled")
  // a completed measurement never coincides with the trigger pulse
  `USRNG_ASSERT_NOW(a_trig_done, !out_tvalid || !(item.trigger_out && item.distance_done), "trigger during done")

endmodule

bind ultrasonic_ranger_with_segment_display_top usrng_checker u_usrng_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);

// File: tb/tb_ultrasonic_ranger_with_segment_display_top.sv
module tb_ultrasonic_ranger_with_segment_display_top;
  import usrng_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_COUNT} ranger_phase_e;

  localparam cfg_idx_t REG_SPARE_LO = 3'd6;
  localparam cfg_idx_t REG_SPARE_HI = 3'd7;
  localparam int STALL_CYCLES = 400;
  localparam int RANDOM_TICKS = 650;
  localparam logic [79:0] GLYPHS = {8'h90, 8'h80, 8'hf8, 8'h82, 8'h92,
                                    8'h99, 8'hb0, 8'ha4, 8'hf9, 8'hc0};

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;    // [0] echo_level
  logic out_tvalid;
  logic out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [0] trigger_out, [4:1] digit_enable, [12:5] segments,
                                      // [26:13] distance, [27] distance_done,
                                      // [28] no_echo_indicator
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  logic steady;
  logic stall_req;

  // register shadow
  logic [9:0]  cf_trigger;
  logic [15:0] cf_timeout;
  logic [17:0] cf_num;
  logic [17:0] cf_den;
  logic [15:0] cf_dwell;
  logic [15:0] cf_interval;

  // ranger state as predicted
  ranger_phase_e rg_phase;
  logic [15:0] rg_ticks;
  logic [15:0] rg_echo;
  logic [13:0] rg_dist;
  logic [1:0]  rg_digit;
  logic [15:0] rg_dwell;
  logic        rg_flag;

  out_item_t expected_readouts[$];
  out_item_t seen_readout;
  out_item_t due_readout;
  int readout_errors = 0;
  int ticks_sent = 0;

  ultrasonic_ranger_with_segment_display_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  task automatic reset_ranger_model();
    cf_trigger = 10'd20;
    cf_timeout = 16'd6400;
    cf_num = 18'd126000;
    cf_den = 18'd120000;
    cf_dwell = 16'd1250;
    cf_interval = 16'd60000;
    rg_phase = PH_IDLE;
    rg_ticks = '0;
    rg_echo = '0;
    rg_dist = '0;
    rg_digit = '0;
    rg_dwell = '0;
    rg_flag = 1'b0;
  endtask

  function automatic logic [13:0] scaled_distance(input logic [15:0] cnt);
    longint unsigned d;
    d = cnt;
    d = (d * 17) / 100;
    if (cf_den == '0) return DIST_MAX;
    d = (d * cf_num) / cf_den;
    return (d > DIST_MAX) ? DIST_MAX : d[13:0];
  endfunction

  function automatic out_item_t step_ranger(input logic echo);
    out_item_t r;
    logic done;
    int unsigned shown;
    int k;
    r = '0;
    done = 1'b0;
    case (rg_phase)
      PH_IDLE: begin
        rg_ticks = rg_ticks + 16'd1;
        if (rg_ticks >= cf_interval) begin
          rg_phase = PH_TRIG;
          rg_ticks = '0;
        end
      end
      PH_TRIG: begin
        r.trigger_out = 1'b1;
        rg_ticks = rg_ticks + 16'd1;
        if (rg_ticks >= {6'd0, cf_trigger}) begin
          rg_phase = PH_WAIT;
          rg_ticks = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          rg_phase = PH_COUNT;
          rg_echo = '0;
        end
      end
      default: begin
        if (!echo) begin
          rg_dist = scaled_distance(rg_echo);
          done = 1'b1;
        end else begin
          if (rg_echo != 16'hffff) rg_echo = rg_echo + 16'd1;
          // a full counter is a timeout whatever the register says
          if (rg_echo >= cf_timeout || rg_echo == 16'hffff) begin
            rg_dist = '0;
            rg_flag = ~rg_flag;
            done = 1'b1;
          end
        end
        if (done) begin
          rg_phase = PH_IDLE;
          rg_ticks = '0;
        end
      end
    endcase

    shown = rg_dist;
    for (k = rg_digit + 1; k < 4; k++) shown = shown / 10;
    shown = shown % 10;
    r.digit_enable = ~(4'b0001 << rg_digit);
    r.segments = GLYPHS[shown*8 +: 8];

    rg_dwell = rg_dwell + 16'd1;
    if (rg_dwell >= cf_dwell) begin
      rg_dwell = '0;
      rg_digit = rg_digit + 2'd1;
    end

    r.distance = rg_dist;
    r.distance_done = done;
    r.no_echo_indicator = rg_flag;
    return r;
  endfunction

  task automatic send_tick(input logic echo);
    if (!steady) begin
      while ($urandom_range(99) < 21) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TDATA_W-1){1'b0}}, echo};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_readouts.push_back(step_ranger(echo));
    ticks_sent++;
  endtask

  // one ranging cycle: ignored lead-in, echo low for gap ticks, high for up to width + 1 ticks, then low
  task automatic range_once(input int gap, input int width, input bit noisy);
    while (rg_phase != PH_WAIT) send_tick(noisy ? ($urandom_range(1) != 0) : 1'b0);
    repeat (gap) send_tick(1'b0);
    send_tick(1'b1);
    repeat (width) if (rg_phase == PH_COUNT) send_tick(1'b1);
    if (rg_phase == PH_COUNT) send_tick(1'b0);
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input cfg_idx_t idx, input logic wr, input logic [31:0] val,
                            output logic [31:0] rd);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    logic [31:0] kept;
    logic [31:0] rd;
    kept = '0;
    apb_access(idx, 1'b1, val, rd);
    case (idx)
      REG_TRIGGER: begin
        cf_trigger = val[9:0];
        kept = {22'd0, val[9:0]};
      end
      REG_TIMEOUT: begin
        cf_timeout = val[15:0];
        kept = {16'd0, val[15:0]};
      end
      REG_NUM: begin
        cf_num = val[17:0];
        kept = {14'd0, val[17:0]};
      end
      REG_DEN: begin
        cf_den = val[17:0];
        kept = {14'd0, val[17:0]};
      end
      REG_DWELL: begin
        cf_dwell = val[15:0];
        kept = {16'd0, val[15:0]};
      end
      REG_INTERVAL: begin
        cf_interval = val[15:0];
        kept = {16'd0, val[15:0]};
      end
      default: ;
    endcase
    if (idx <= REG_INTERVAL) begin
      apb_access(idx, 1'b0, '0, rd);
      if (rd != kept) begin
        readout_errors++;
        $display("%0t: register %0d readback mismatch, expected %h, got %h",
                 $time, idx, kept, rd);
      end
    end
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      readout_errors++;
      if (readout_errors <= 200)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_readout = out_item_t'(out_tdata);
      if (expected_readouts.size() == 0) begin
        readout_errors++;
        $display("%0t: result with none expected, expected nothing, got %h",
                 $time, out_tdata);
      end else begin
        due_readout = expected_readouts.pop_front();
        check_field("trigger_out", due_readout.trigger_out, seen_readout.trigger_out);
        check_field("digit_enable", due_readout.digit_enable, seen_readout.digit_enable);
        check_field("segments", due_readout.segments, seen_readout.segments);
        check_field("distance", due_readout.distance, seen_readout.distance);
        check_field("distance_done", due_readout.distance_done, seen_readout.distance_done);
        check_field("no_echo_indicator", due_readout.no_echo_indicator,
                    seen_readout.no_echo_indicator);
        check_field("padding", 0, seen_readout.pad);
      end
    end
  end

  // result side: random idling, or a long counted hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (stall_req) begin
        out_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_req <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 21);
      end
    end
  end

  task automatic test_reset_state();
    // long default interval: echo is ignored, display shows zero
    repeat (12) send_tick($urandom_range(1) != 0);
    wait_quiet();
  endtask

  task automatic test_registers();
    write_reg(REG_TRIGGER, 32'd3);
    write_reg(REG_TIMEOUT, 32'd12);
    write_reg(REG_NUM, 32'd5);
    write_reg(REG_DEN, 32'd4);
    write_reg(REG_DWELL, 32'd2);
    write_reg(REG_INTERVAL, 32'd4);
    // writes beyond the register map must leave everything alone
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    range_once(1, 6, 1'b1);
    wait_quiet();
  endtask

  task automatic test_special_cases();
    // saturation at 9999
    write_reg(REG_NUM, 32'd262143);
    write_reg(REG_DEN, 32'd1);
    write_reg(REG_TIMEOUT, 32'd100);
    range_once(0, 8, 1'b0);
    wait_quiet();
    // zero registers act as one, zero timeout ends on the first counted tick
    write_reg(REG_TRIGGER, 32'd0);
    write_reg(REG_INTERVAL, 32'd0);
    write_reg(REG_DWELL, 32'd0);
    write_reg(REG_TIMEOUT, 32'd0);
    range_once(2, 3, 1'b1);
    range_once(0, 1, 1'b0);
    wait_quiet();
    // zero denominator, echo that falls at once, echo that is late to rise
    write_reg(REG_TIMEOUT, 32'd50);
    write_reg(REG_DEN, 32'd0);
    range_once(0, 2, 1'b0);
    wait_quiet();
    write_reg(REG_DEN, 32'd3);
    range_once(12, 0, 1'b0);
    wait_quiet();
  endtask

  task automatic test_extremes();
    steady <= 1'b1;
    // top values of every register, wider writes are cut to the register width
    write_reg(REG_INTERVAL, 32'd65535);
    write_reg(REG_TRIGGER, 32'hffffffff);
    write_reg(REG_TIMEOUT, 32'd65535);
    write_reg(REG_DWELL, 32'd65535);
    write_reg(REG_NUM, 32'hffffffff);
    write_reg(REG_DEN, 32'd262143);
    repeat (8) send_tick(1'b0);
    wait_quiet();
    write_reg(REG_INTERVAL, 32'd1);
    write_reg(REG_TRIGGER, 32'd1);
    write_reg(REG_DWELL, 32'd1);
    write_reg(REG_DEN, 32'd70000);
    // long echo with no idling on either side
    range_once(0, 300, 1'b0);
    wait_quiet();
    steady <= 1'b0;
  endtask

  task automatic test_backpressure();
    write_reg(REG_INTERVAL, 32'd2);
    write_reg(REG_TRIGGER, 32'd2);
    write_reg(REG_TIMEOUT, 32'd40);
    write_reg(REG_DWELL, 32'd3);
    write_reg(REG_NUM, 32'd1500);
    write_reg(REG_DEN, 32'd7);
    stall_req <= 1'b1;
    repeat (4) range_once($urandom_range(0, 4), $urandom_range(5, 45), 1'b1);
    wait_quiet();
  endtask

  task automatic test_random();
    int stop_at;
    int phase_end;
    stop_at = ticks_sent + RANDOM_TICKS;
    while (ticks_sent < stop_at) begin
      wait_quiet();
      write_reg(REG_TRIGGER, $urandom_range(0, 6));
      write_reg(REG_TIMEOUT, ($urandom_range(4) == 0) ? $urandom_range(0, 3)
                                                      : $urandom_range(4, 120));
      write_reg(REG_NUM, ($urandom_range(1) != 0) ? $urandom() : $urandom_range(1, 2000));
      case ($urandom_range(9))
        0: write_reg(REG_DEN, 32'd0);
        1, 2, 3, 4: write_reg(REG_DEN, $urandom());
        default: write_reg(REG_DEN, $urandom_range(1, 400));
      endcase
      write_reg(REG_DWELL, $urandom_range(0, 6));
      write_reg(REG_INTERVAL, $urandom_range(0, 8));
      phase_end = ticks_sent + 220;
      while (ticks_sent < phase_end) begin
        if ($urandom_range(99) < 85)
          range_once($urandom_range(0, 6), $urandom_range(0, cf_timeout + 4), 1'b1);
        else
          repeat ($urandom_range(1, 8)) send_tick($urandom_range(1) != 0);
      end
    end
    wait_quiet();
  endtask

  task automatic finish_run();
    int n;
    n = 0;
    in_tvalid <= 1'b0;
    while (expected_readouts.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (100) @(posedge clk);
    if (expected_readouts.size() != 0)
      $display("%0t: %0d results never arrived", $time, expected_readouts.size());
    if (readout_errors == 0 && expected_readouts.size() == 0) begin
      $display("ultrasonic_ranger_with_segment_display_top test passed");
    end else begin
      $display("ultrasonic_ranger_with_segment_display_top test failed");
    end
    $finish;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    steady <= 1'b0;
    stall_req <= 1'b0;
    reset_ranger_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_registers();
    test_special_cases();
    test_extremes();
    test_backpressure();
    test_random();
    finish_run();
  end

  initial begin
    #5000000;
    $display("ultrasonic_ranger_with_segment_display_top test failed");
    $finish;
  end

endmodule
